// ----- src/plru_pkg.sv -----
package plru_pkg;

    // Default sizing of the tracker.
    localparam int PAGE_SIZE_DEF    = 256;
    localparam int MAX_RES_DEF      = 8;
    localparam int INDEX_BITS_DEF   = 24;

    // Fixed widths of the result fields and the limit register.
    localparam int PAGE_NUM_W       = 16;
    localparam int PAGE_OFF_W       = 8;
    localparam int CFG_W            = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Per-access control broadcast to every cell of the list.
    typedef struct packed {
        logic en;       // an access word is accepted this cycle
        logic found;    // the page is resident somewhere in the list
        logic insert;   // the list is below the limit: a miss grows it by one
    } t_cell_ctrl;

endpackage

// ----- src/plru_cell.sv -----
module plru_cell
    import plru_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int PAGE_W = 16,
    parameter int CNT_W  = 4
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [PAGE_W-1:0] i_page,
    input  logic [PAGE_W-1:0] i_prev_page,
    input  logic              i_hit_chain,
    input  logic [PAGE_W-1:0] i_victim_chain,
    output logic [PAGE_W-1:0] o_page,
    output logic              o_hit_chain,
    output logic [PAGE_W-1:0] o_victim_chain
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_N = CNT_W'(IDX + 1);

    logic [PAGE_W-1:0] r_page;
    logic [PAGE_W-1:0] n_page;
    logic              valid;
    logic              prev_valid;
    logic              last;
    logic              hit;
    logic              load;

    // This entry and its upper neighbor are valid while inside the fill count.
    assign valid      = IDX_C < i_count;
    assign prev_valid = IDX_C <= i_count;
    assign last       = IDX_N == i_count;

    // Match against the accessed page; the chain flags a hit here or further back.
    assign hit         = valid && (r_page == i_page);
    assign o_hit_chain = hit | i_hit_chain;

    // The least recent entry is passed toward the front of the row.
    assign o_victim_chain = (last ? r_page : '0) | i_victim_chain;

    // Shift from the neighbor when this entry lies in the moving part of the list.
    always_comb begin
        if (i_ctrl.found) begin
            load = o_hit_chain;
        end else if (i_ctrl.insert) begin
            load = prev_valid;
        end else begin
            load = valid;
        end
        n_page = (i_ctrl.en && load) ? i_prev_page : r_page;
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

    assign o_page = r_page;

endmodule

// ----- src/paged_lru_residency_tracker.sv -----
// A result word is registered and presented in the cycle after its access word is accepted.
// Throughput: one access word per cycle while results are taken as they appear; the
// whole recency row compares and shifts in the accept cycle. A result left waiting
// holds the input off until the cycle in which it is taken.
// Reset (synchronous, active low): empties the list, sets the limit register to 8
// and clears the output valid; list entries themselves are not cleared.
module paged_lru_residency_tracker
    import plru_pkg::*;
#(
    parameter int PAGE_SIZE    = PAGE_SIZE_DEF,
    parameter int MAX_RESIDENT = MAX_RES_DEF,
    parameter int INDEX_BITS   = INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [INDEX_BITS-1:0] i_element_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PAGE_NUM_W-1:0] o_page_number,
    output logic [PAGE_OFF_W-1:0] o_page_offset,
    output logic                  o_hit,
    output logic                  o_evicted_valid,
    output logic [PAGE_NUM_W-1:0] o_evicted_page,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int OFF_W  = $clog2(PAGE_SIZE);
    localparam int PAGE_W = INDEX_BITS - OFF_W;
    localparam int CNT_W  = $clog2(MAX_RESIDENT + 1);
    localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [LIM_W-1:0] MAX_L = LIM_W'(MAX_RESIDENT);
    localparam logic [LIM_W-1:0] ONE_L = LIM_W'(1);

    logic [CFG_W-1:0]      r_resident_pages;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [PAGE_NUM_W-1:0] r_page_number;
    logic [PAGE_OFF_W-1:0] r_page_offset;
    logic                  r_hit;
    logic                  r_evicted_valid;
    logic [PAGE_NUM_W-1:0] r_evicted_page;

    logic                  in_accept;
    logic [PAGE_W-1:0]     in_page;
    logic [OFF_W-1:0]      in_offset;
    logic [LIM_W-1:0]      cfg_l;
    logic [LIM_W-1:0]      limit;
    logic                  insert;
    logic                  evict;
    t_cell_ctrl            ctrl;

    logic [PAGE_W-1:0]     w_page   [MAX_RESIDENT];
    logic                  w_hit    [MAX_RESIDENT+1];
    logic [PAGE_W-1:0]     w_victim [MAX_RESIDENT+1];

    // Accept while the output register is empty or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Split the index into page number and offset.
    assign in_page   = i_element_index[INDEX_BITS-1:OFF_W];
    assign in_offset = i_element_index[OFF_W-1:0];

    // Effective limit: clamp the register into one through the list depth.
    always_comb begin
        cfg_l = LIM_W'(r_resident_pages);
        if (cfg_l < ONE_L) begin
            limit = ONE_L;
        end else if (cfg_l > MAX_L) begin
            limit = MAX_L;
        end else begin
            limit = cfg_l;
        end
    end

    assign insert = LIM_W'(r_count) < limit;
    assign evict  = !w_hit[0] && !insert;

    assign ctrl.en     = in_accept;
    assign ctrl.found  = w_hit[0];
    assign ctrl.insert = insert;

    // Tail of the row: no hit and no victim beyond the last cell.
    assign w_hit[MAX_RESIDENT]    = 1'b0;
    assign w_victim[MAX_RESIDENT] = '0;

    // Row of recency cells, front (most recent) at index zero.
    for (genvar g = 0; g < MAX_RESIDENT; g++) begin : g_cell
        logic [PAGE_W-1:0] prev_page;
        if (g == 0) begin : g_front
            assign prev_page = in_page;
        end else begin : g_body
            assign prev_page = w_page[g-1];
        end
        plru_cell #(
            .IDX    (g),
            .PAGE_W (PAGE_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctrl         (ctrl),
            .i_count        (r_count),
            .i_page         (in_page),
            .i_prev_page    (prev_page),
            .i_hit_chain    (w_hit[g+1]),
            .i_victim_chain (w_victim[g+1]),
            .o_page         (w_page[g]),
            .o_hit_chain    (w_hit[g]),
            .o_victim_chain (w_victim[g])
        );
    end

    // The list grows only on a miss below the limit.
    assign n_count = (in_accept && !w_hit[0] && insert) ? r_count + CNT_W'(1) : r_count;

    // Control state and the limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resident_pages <= CFG_RESET;
            r_count          <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_resident_pages <= i_cfg_data;
            end
            r_count <= n_count;
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_page_number   <= PAGE_NUM_W'(in_page);
            r_page_offset   <= PAGE_OFF_W'(in_offset);
            r_hit           <= w_hit[0];
            r_evicted_valid <= evict;
            r_evicted_page  <= evict ? PAGE_NUM_W'(w_victim[0]) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_page_number   = r_page_number;
    assign o_page_offset   = r_page_offset;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_evicted_valid;
    assign o_evicted_page  = r_evicted_page;

`ifndef SYNTHESIS
    // The fill count never passes the depth of the row.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RESIDENT))
        else $error("resident count exceeds list depth");

    // Reset leaves the list empty.
    a_count_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_count == '0)
        else $error("resident count not cleared by reset");

    // The count moves only when a word is accepted.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_count))
        else $error("resident count changed without an access");

    // A hit never evicts, and the reported page is zero without an eviction.
    a_hit_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_evicted_valid))
        else $error("hit and eviction reported together");

    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_evicted_valid) |-> r_evicted_page == '0)
        else $error("evicted page nonzero without eviction");
`endif

endmodule

// ----- tb/paged_lru_residency_tracker_test.sv -----
module paged_lru_residency_tracker_test
    import plru_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W        = INDEX_BITS_DEF;
    localparam int RANDOM_WORDS = 500;
    localparam int PHASE_WORDS  = 125;
    localparam int POOL_SIZE    = 12;
    localparam int HOLD_CYCLES  = 60;

    // One result word, field by field.
    typedef struct packed {
        logic [PAGE_NUM_W-1:0] page;
        logic [PAGE_OFF_W-1:0] offset;
        logic                  hit;
        logic                  ev_valid;
        logic [PAGE_NUM_W-1:0] ev_page;
    } t_access_result;

    // One row of the directed walk: an optional limit write, then one access word.
    typedef struct {
        bit                    cfg_en;
        logic [CFG_W-1:0]      cfg_val;
        logic [IDX_W-1:0]      idx;
        bit                    typed;
        t_access_result        exp;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [IDX_W-1:0]      i_element_index;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [PAGE_NUM_W-1:0] o_page_number;
    logic [PAGE_OFF_W-1:0] o_page_offset;
    logic                  o_hit;
    logic                  o_evicted_valid;
    logic [PAGE_NUM_W-1:0] o_evicted_page;
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_cfg_data;

    // Shadow of the tracker: recency list, fill level and the limit register.
    logic [PAGE_NUM_W-1:0] lru_pages [MAX_RES_DEF];
    int unsigned           held_count;
    logic [CFG_W-1:0]      limit_reg;

    t_access_result        access_results_due [$];
    int unsigned           err_count;
    int unsigned           words_sent;
    int unsigned           hits_seen;
    int unsigned           evicts_seen;
    int unsigned           rx_cycle;
    bit                    calm;

    // Hand-checked rows carry their result; the rest rely on the shadow tracker.
    t_dir_row dir_rows [18] = '{
        '{1'b1, 4'd0,  24'h000000, 1'b1, '{16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000}},
        '{1'b0, 4'd0,  24'h000105, 1'b1, '{16'h0001, 8'h05, 1'b0, 1'b1, 16'h0000}},
        '{1'b0, 4'd0,  24'h0001FF, 1'b1, '{16'h0001, 8'hFF, 1'b1, 1'b0, 16'h0000}},
        '{1'b1, 4'd1,  24'hFFFFFF, 1'b1, '{16'hFFFF, 8'hFF, 1'b0, 1'b1, 16'h0001}},
        '{1'b1, 4'd15, 24'h000000, 1'b1, '{16'h0000, 8'h00, 1'b0, 1'b0, 16'h0000}},
        '{1'b0, 4'd0,  24'h000280, 1'b0, '0},
        '{1'b0, 4'd0,  24'h000311, 1'b0, '0},
        '{1'b0, 4'd0,  24'h000422, 1'b0, '0},
        '{1'b0, 4'd0,  24'h000533, 1'b0, '0},
        '{1'b0, 4'd0,  24'h000644, 1'b0, '0},
        '{1'b0, 4'd0,  24'h000755, 1'b0, '0},
        '{1'b0, 4'd0,  24'h123456, 1'b0, '0},
        '{1'b0, 4'd0,  24'h0003C0, 1'b0, '0},
        '{1'b1, 4'd2,  24'h0A0000, 1'b0, '0},
        '{1'b0, 4'd0,  24'h000701, 1'b0, '0},
        '{1'b1, 4'd8,  24'h00AA55, 1'b0, '0},
        '{1'b0, 4'd0,  24'h555555, 1'b0, '0},
        '{1'b0, 4'd0,  24'hAAAAAA, 1'b0, '0}
    };

    paged_lru_residency_tracker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_element_index (i_element_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_page_number   (o_page_number),
        .o_page_offset   (o_page_offset),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Applies one access to the shadow list and returns the word it should produce.
    function automatic t_access_result track_access(input logic [IDX_W-1:0] idx);
        t_access_result r;
        int unsigned    lim;
        int unsigned    pos;
        int unsigned    shift_n;
        int unsigned    i;
        bit             found;
        r       = '0;
        found   = 1'b0;
        pos     = 0;
        lim     = limit_reg;
        if (lim < 1) lim = 1;
        if (lim > MAX_RES_DEF) lim = MAX_RES_DEF;
        r.page   = PAGE_NUM_W'(idx / PAGE_SIZE_DEF);
        r.offset = PAGE_OFF_W'(idx % PAGE_SIZE_DEF);
        for (i = 0; i < held_count; i++) begin
            if (!found && lru_pages[i] == r.page) begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (found) begin
            r.hit   = 1'b1;
            shift_n = pos;
        end else if (held_count < lim) begin
            shift_n = held_count;
            held_count++;
        end else begin
            // At or above the limit a miss replaces the least recent page.
            r.ev_valid = 1'b1;
            r.ev_page  = lru_pages[held_count-1];
            shift_n    = held_count - 1;
        end
        for (i = shift_n; i > 0; i--) begin
            if (i < MAX_RES_DEF) lru_pages[i] = lru_pages[i-1];
        end
        lru_pages[0] = r.page;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // Offers one access word after an optional gap and holds it until it is taken.
    task automatic send_word(input logic [IDX_W-1:0] idx, input bit typed,
                             input t_access_result typed_exp);
        int unsigned    gap;
        t_access_result pred;
        gap = 0;
        if (!calm && $urandom_range(99) < 16) gap = $urandom_range(4, 1);
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_element_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        pred = track_access(idx);
        access_results_due = {access_results_due, (typed ? typed_exp : pred)};
        words_sent++;
    endtask

    // Limit writes happen only once every outstanding result has been taken.
    task automatic write_limit(input logic [CFG_W-1:0] val);
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (access_results_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        limit_reg = val;
    endtask

    // Result side: compare each taken word with the oldest expectation.
    always @(posedge i_clk) begin
        t_access_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (access_results_due.size() == 0) begin
                $error("result word with nothing expected: page %0h", o_page_number);
                err_count++;
            end else begin
                e = access_results_due.pop_front();
                check_field("page_number", e.page, o_page_number);
                check_field("page_offset", e.offset, o_page_offset);
                check_field("hit", e.hit, o_hit);
                check_field("evicted_valid", e.ev_valid, o_evicted_valid);
                check_field("evicted_page", e.ev_page, o_evicted_page);
                if (o_hit) hits_seen++;
                if (o_evicted_valid) evicts_seen++;
            end
        end
    end

    // Receiver: random stalls, two long hold-offs to back the block up, and a calm stretch.
    initial begin
        i_out_ready = 1'b0;
        rx_cycle    = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle == 300 || rx_cycle == 650) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (rx_cycle >= 800 && rx_cycle < 1000) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    // Guard against a hung handshake.
    initial begin
        #400_000;
        $display("paged_lru_residency_tracker_test: done, errors");
        $finish;
    end

    // Stimulus: reset, the directed walk, then random phases under several limits.
    initial begin
        logic [PAGE_NUM_W-1:0] page_pool [POOL_SIZE];
        logic [PAGE_NUM_W-1:0] page;
        logic [IDX_W-1:0]      idx;
        logic [CFG_W-1:0]      phase_limit;
        int unsigned           r;
        int unsigned           drain;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_element_index = '0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        err_count       = 0;
        words_sent      = 0;
        hits_seen       = 0;
        evicts_seen     = 0;
        held_count      = 0;
        limit_reg       = CFG_RESET;
        calm            = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].cfg_en) write_limit(dir_rows[k].cfg_val);
            send_word(dir_rows[k].idx, dir_rows[k].typed, dir_rows[k].exp);
        end

        for (int ph = 0; ph < RANDOM_WORDS / PHASE_WORDS; ph++) begin
            case (ph)
                0: phase_limit = CFG_W'($urandom_range(15, 0));
                1: phase_limit = 4'd3;
                2: phase_limit = 4'd15;
                default: phase_limit = CFG_W'($urandom_range(8, 1));
            endcase
            write_limit(phase_limit);
            // A small working set keeps hits and evictions frequent.
            foreach (page_pool[p]) page_pool[p] = PAGE_NUM_W'($urandom);
            calm = (ph == 2);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                r = $urandom_range(99);
                if (r < 20 && held_count > 0) begin
                    page = lru_pages[$urandom_range(held_count - 1, 0)];
                    idx  = {page, PAGE_OFF_W'($urandom)};
                end else if (r < 80) begin
                    page = page_pool[$urandom_range(POOL_SIZE - 1, 0)];
                    idx  = {page, PAGE_OFF_W'($urandom)};
                end else begin
                    idx = IDX_W'($urandom);
                end
                send_word(idx, 1'b0, '0);
            end
        end
        calm = 1'b0;

        // Let every outstanding result drain before the final check.
        @(negedge i_clk) i_in_valid <= 1'b0;
        drain = 0;
        while (access_results_due.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4) @(posedge i_clk);
        if (access_results_due.size() != 0) begin
            $error("%0d result words never arrived", access_results_due.size());
            err_count++;
        end

        $display("Covered %0d access words across limits 0 to 15, with %0d hits and %0d evictions,",
                 words_sent, hits_seen, evicts_seen);
        $display("under random stalls on both sides and two long output hold-offs.");
        if (err_count == 0) begin
            $display("paged_lru_residency_tracker_test: done, clean");
        end else begin
            $display("paged_lru_residency_tracker_test: done, errors");
        end
        $finish;
    end

endmodule

// ----- paged_lru_residency_tracker.f -----
src/plru_pkg.sv
src/plru_cell.sv
src/paged_lru_residency_tracker.sv
tb/paged_lru_residency_tracker_test.sv
